// ===== rtl/ravg_pkg.sv =====
// Shared constants, codes and types for the range-average prefix-sum block.
`timescale 1ns / 1ps

package ravg_pkg;

    // Array capacity and the widths that follow from it.
    localparam int MAX_ELEMENTS = 1024;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DEPTH        = MAX_ELEMENTS + 1;
    localparam int ADDR_W       = $clog2(DEPTH);

    // Field widths of the words on the two channels.
    localparam int REQ_W  = 2;
    localparam int VAL_W  = 8;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int AVG_W  = 8;

    // A running sum of up to MAX_ELEMENTS signed bytes.
    localparam int SUM_W = VAL_W + $clog2(MAX_ELEMENTS);

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Request from the control logic to the divider.
    typedef struct packed {
        logic               start;
        logic               negate;
        logic [SUM_W-1:0]   magnitude;
        logic [IDX_W-1:0]   divisor;
    } div_req_t;

endpackage

// ===== rtl/ravg_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module ravg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ravg_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, signed result truncated toward zero.
`timescale 1ns / 1ps

module ravg_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ravg_pkg::div_req_t              req,
    output logic                            done,
    output logic signed [ravg_pkg::AVG_W-1:0] quotient
);

    localparam int STEP_W = $clog2(ravg_pkg::SUM_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [ravg_pkg::SUM_W-1:0]    quo_reg;
    logic [ravg_pkg::IDX_W-1:0]    rem_reg;
    logic [ravg_pkg::IDX_W-1:0]    div_reg;

    logic [ravg_pkg::IDX_W:0]      shifted;
    logic                          fits;
    logic [ravg_pkg::IDX_W:0]      diff;
    logic [ravg_pkg::AVG_W-1:0]    q_low;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[ravg_pkg::SUM_W-1]};
        diff    = shifted - {1'b0, div_reg};
        fits    = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ravg_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.magnitude;
            rem_reg <= '0;
            div_reg <= req.divisor;
            neg_reg <= req.negate;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[ravg_pkg::SUM_W-2:0], fits};
            rem_reg <= fits ? diff[ravg_pkg::IDX_W-1:0] : shifted[ravg_pkg::IDX_W-1:0];
        end
    end

    // The magnitude of an average of bytes never exceeds 128, so the low bits suffice.
    assign q_low    = quo_reg[ravg_pkg::AVG_W-1:0];
    assign quotient = neg_reg ? (~q_low + ravg_pkg::AVG_W'(1)) : q_low;
    assign done     = done_reg;

endmodule

// ===== rtl/range_average_prefix_sum.sv =====
// Top level of the range-average block: request decode, prefix-sum table and result register.
`timescale 1ns / 1ps

// The block keeps an array of signed bytes as a table of running sums in one
// synchronous RAM and answers range-average queries from it.
// Each input word carries req_type, value, first_index and end_index; it is
// taken when in_valid and in_ready are both high. An append stores the new
// running sum, a clear empties the array, and a query returns the sum of
// elements first_index through end_index-1 divided by their count, truncated
// toward zero. Every input word gives exactly one output word (status and
// average) on the out_valid/out_ready channel, in order.
// Append, clear and rejected or empty queries go from acceptance
// through S_RESULT to the output register. A query over a nonempty range
// reads two table entries through the single RAM read port (S_READ_A,
// S_READ_B) and then runs the restoring divider, one quotient bit per cycle
// over the 18-bit sum, in S_DIV before S_RESULT. One word is processed at a
// time and in_ready returns as the result register loads, so a new word is
// taken only once the previous result has moved to the output register.
// The output word sits in a register; a new input word is accepted while it
// waits, but the next result holds in the block until the receiver takes the
// previous one. in_ready stays low during that wait.
// Reset clears the element count, the running sum and out_valid. No clearing
// pass over the RAM is needed: entries above the count are never used.

module range_average_prefix_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ravg_pkg::REQ_W-1:0]          req_type,
    input  logic signed [ravg_pkg::VAL_W-1:0]   value,
    input  logic [ravg_pkg::IDX_W-1:0]          first_index,
    input  logic [ravg_pkg::IDX_W-1:0]          end_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ravg_pkg::STAT_W-1:0]         status,
    output logic signed [ravg_pkg::AVG_W-1:0]   average
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_DIV,
        S_RESULT
    } state_t;

    state_t                                 state_reg;
    logic [ravg_pkg::CNT_W-1:0]             count_reg;
    logic signed [ravg_pkg::SUM_W-1:0]      last_sum_reg;
    logic [ravg_pkg::IDX_W-1:0]             a_reg;
    logic [ravg_pkg::IDX_W-1:0]             b_reg;
    logic signed [ravg_pkg::SUM_W-1:0]      sum_a_reg;
    ravg_pkg::status_t                      res_status_reg;
    logic signed [ravg_pkg::AVG_W-1:0]      res_avg_reg;
    logic                                   out_valid_reg;
    ravg_pkg::status_t                      out_status_reg;
    logic signed [ravg_pkg::AVG_W-1:0]      out_avg_reg;

    logic                                   accept;
    logic                                   full;
    logic                                   range_bad;
    logic signed [ravg_pkg::SUM_W-1:0]      new_sum;
    logic                                   ram_we;
    logic [ravg_pkg::ADDR_W-1:0]            ram_waddr;
    logic                                   ram_re;
    logic [ravg_pkg::ADDR_W-1:0]            ram_raddr;
    logic [ravg_pkg::SUM_W-1:0]             ram_rdata;
    logic signed [ravg_pkg::SUM_W-1:0]      range_sum;
    ravg_pkg::div_req_t                     div_req;
    logic                                   div_done;
    logic signed [ravg_pkg::AVG_W-1:0]      div_quot;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign full      = (count_reg >= ravg_pkg::CNT_W'(ravg_pkg::MAX_ELEMENTS));
    assign range_bad = (first_index > end_index) || (int'(end_index) > int'(count_reg));
    assign new_sum   = last_sum_reg
                     + {{(ravg_pkg::SUM_W - ravg_pkg::VAL_W){value[ravg_pkg::VAL_W-1]}}, value};

    // The write of an append lands at the acceptance edge. A query never
    // writes, and every entry it uses was written by an earlier append, so a
    // read that matters never meets a write on the same entry.
    assign ram_we    = accept && (req_type == ravg_pkg::REQ_APPEND) && !full;
    assign ram_waddr = ravg_pkg::ADDR_W'(count_reg + ravg_pkg::CNT_W'(1));
    assign ram_re    = (state_reg == S_IDLE) || (state_reg == S_READ_A);
    assign ram_raddr = (state_reg == S_IDLE) ? ravg_pkg::ADDR_W'(first_index)
                                             : ravg_pkg::ADDR_W'(b_reg);

    ravg_ram #(
        .WIDTH (ravg_pkg::SUM_W),
        .DEPTH (ravg_pkg::DEPTH)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (new_sum),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // In S_READ_B the end entry arrives; the difference goes to the divider as
    // a magnitude and a sign so that the quotient truncates toward zero.
    always_comb
    begin
        range_sum         = $signed(ram_rdata) - sum_a_reg;
        div_req.start     = (state_reg == S_READ_B);
        div_req.negate    = range_sum[ravg_pkg::SUM_W-1];
        div_req.magnitude = range_sum[ravg_pkg::SUM_W-1] ? (-range_sum) : range_sum;
        div_req.divisor   = b_reg - a_reg;
    end

    ravg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // In S_RESULT the output register is reloaded below instead.
            if (out_valid_reg && out_ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg          <= first_index;
                        b_reg          <= end_index;
                        res_status_reg <= ravg_pkg::ST_OK;
                        res_avg_reg    <= '0;
                        state_reg      <= S_RESULT;
                        case (req_type)
                            ravg_pkg::REQ_APPEND:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= ravg_pkg::ST_FULL;
                                end
                                else
                                begin
                                    last_sum_reg <= new_sum;
                                    count_reg    <= count_reg + ravg_pkg::CNT_W'(1);
                                end
                            end
                            ravg_pkg::REQ_QUERY:
                            begin
                                if (range_bad)
                                begin
                                    res_status_reg <= ravg_pkg::ST_BAD_RANGE;
                                end
                                else if (first_index != end_index)
                                begin
                                    state_reg <= S_READ_A;
                                end
                            end
                            ravg_pkg::REQ_CLEAR:
                            begin
                                count_reg    <= '0;
                                last_sum_reg <= '0;
                            end
                            default:
                            begin
                                // Unused code: answered with an ok word.
                            end
                        endcase
                    end
                end

                S_READ_A:
                begin
                    // Entry zero is the empty sum and is never written.
                    sum_a_reg <= (a_reg == '0) ? '0 : $signed(ram_rdata);
                    state_reg <= S_READ_B;
                end

                S_READ_B:
                begin
                    state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_avg_reg <= div_quot;
                        state_reg   <= S_RESULT;
                    end
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_avg_reg    <= res_avg_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign average   = out_avg_reg;

    // The element count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= ravg_pkg::MAX_ELEMENTS)
        else $error("element count above capacity");

    // The divider finishes only while the control waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider done outside the divide state");

    // A word with an error status carries a zero average.
    a_err_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ravg_pkg::ST_OK)) |-> (out_avg_reg == '0))
        else $error("error word with nonzero average");

    // A clear empties the array at once.
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == ravg_pkg::REQ_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the array");

endmodule
